>>> rtl/keypad_code_lock_with_lockout_macros.svh
// assertion macros used by the code lock core
`ifndef KEYPAD_CODE_LOCK_WITH_LOCKOUT_MACROS_SVH
`define KEYPAD_CODE_LOCK_WITH_LOCKOUT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define KCL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define KCL_ASSERT_IMPL(label, ante, cons, msg) \
	`KCL_ASSERT(label, (ante) |-> (cons), msg)

`endif

>>> rtl/kcl_pkg.sv
// shared types and constants of the keypad code lock
`default_nettype none
package kcl_pkg;
	localparam int CODE_LEN = 4;
	localparam int POS_W    = 5;
	localparam int SEC_W    = 10;
	localparam int TRIAL_W  = 4;
	localparam int TMO_W    = 8;
	localparam int STAT_W   = 4;
	localparam int MODE_W   = 2;
	localparam int FUNC_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [SEC_W-1:0]   SEC_MAX          = '1;
	localparam logic [TMO_W-1:0]   ENTRY_TMO_RST    = TMO_W'(10);
	localparam logic [TMO_W-1:0]   NEW_TMO_RST      = TMO_W'(30);
	localparam logic [TRIAL_W-1:0] MAX_TRIALS_RST   = TRIAL_W'(5);
	localparam logic [SEC_W-1:0]   LOCKOUT_SEC_RST  = SEC_W'(180);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_DIGIT  = 2'd0,
		FUNC_TICK   = 2'd1,
		FUNC_CHANGE = 2'd2,
		FUNC_NOP    = 2'd3
	} kcl_func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_NONE      = 4'd0,
		ST_DIGIT     = 4'd1,
		ST_GRANTED   = 4'd2,
		ST_WRONG     = 4'd3,
		ST_LOCKED    = 4'd4,
		ST_LOCK_OVER = 4'd5,
		ST_TIMEOUT   = 4'd6,
		ST_CHANGED   = 4'd7,
		ST_MISMATCH  = 4'd8
	} kcl_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENTRY_TMO   = 2'd0,
		REG_NEW_TMO     = 2'd1,
		REG_MAX_TRIALS  = 2'd2,
		REG_LOCKOUT_SEC = 2'd3
	} kcl_reg_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              digit;
	} kcl_item_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} kcl_cfg_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [TRIAL_W-1:0] trials_left;
		logic [SEC_W-1:0]   lock_remaining;
		logic [POS_W-1:0]   digits_entered;
		logic [MODE_W-1:0]  mode;
	} kcl_result_t;
endpackage
`default_nettype wire

>>> rtl/kcl_in_stage.sv
// input register stage of the code lock
`default_nettype none
module kcl_in_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire kcl_pkg::kcl_item_t in_item,
	input  wire logic              advance,
	output logic                   valid_s1,
	output kcl_pkg::kcl_item_t     item_s1
);
	import kcl_pkg::*;

	// stage frees up when its transaction moves on this cycle
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end
endmodule
`default_nettype wire

>>> rtl/kcl_core.sv
// lock state, configuration registers and per-event update logic
`default_nettype none
`include "keypad_code_lock_with_lockout_macros.svh"
module kcl_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire kcl_pkg::kcl_cfg_t  cfg,
	input  wire logic               step,
	input  wire kcl_pkg::kcl_item_t item,
	output kcl_pkg::kcl_result_t    result
);
	import kcl_pkg::*;

	typedef enum logic [MODE_W-1:0] {
		MODE_VERIFY  = 2'd0,
		MODE_LOCKED  = 2'd1,
		MODE_NEW     = 2'd2,
		MODE_REENTER = 2'd3
	} mode_t;

	logic [TMO_W-1:0]    entry_tmo_q;
	logic [TMO_W-1:0]    new_tmo_q;
	logic [TRIAL_W-1:0]  max_trials_q;
	logic [SEC_W-1:0]    lockout_sec_q;

	mode_t               mode_q, mode_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [CODE_LEN-1:0] entered_q, entered_d;
	logic [CODE_LEN-1:0] first_q, first_d;
	logic [CODE_LEN-1:0] stored_q, stored_d;
	logic [TRIAL_W-1:0]  trials_q, trials_d;
	logic [SEC_W-1:0]    sec_q, sec_d;
	kcl_status_t         status_d;

	logic [POS_W-1:0]    pos_cur;
	logic [POS_W-1:0]    pos_inc;
	logic [CODE_LEN-1:0] code_new;
	logic [SEC_W-1:0]    sec_inc;
	logic [TMO_W-1:0]    limit;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_tmo_q   <= ENTRY_TMO_RST;
			new_tmo_q     <= NEW_TMO_RST;
			max_trials_q  <= MAX_TRIALS_RST;
			lockout_sec_q <= LOCKOUT_SEC_RST;
		end else if (cfg.we) begin
			unique case (kcl_reg_t'(cfg.index))
				REG_ENTRY_TMO:   entry_tmo_q   <= cfg.data[TMO_W-1:0];
				REG_NEW_TMO:     new_tmo_q     <= cfg.data[TMO_W-1:0];
				REG_MAX_TRIALS:  max_trials_q  <= cfg.data[TRIAL_W-1:0];
				REG_LOCKOUT_SEC: lockout_sec_q <= cfg.data[SEC_W-1:0];
				default: ;
			endcase
		end
	end

	assign pos_cur = (pos_q >= POS_W'(CODE_LEN)) ? '0 : pos_q;
	assign pos_inc = pos_cur + POS_W'(1);
	assign sec_inc = (sec_q == SEC_MAX) ? sec_q : sec_q + SEC_W'(1);
	assign limit   = (mode_q == MODE_NEW) ? new_tmo_q : entry_tmo_q;

	always_comb begin
		for (int i = 0; i < CODE_LEN; i++) begin
			code_new[i] = entered_q[i] | (item.digit && (pos_cur == POS_W'(i)));
		end
	end

	always_comb begin
		mode_d    = mode_q;
		pos_d     = pos_q;
		entered_d = entered_q;
		first_d   = first_q;
		stored_d  = stored_q;
		trials_d  = trials_q;
		sec_d     = sec_q;
		status_d  = ST_NONE;
		unique case (kcl_func_t'(item.func))
			FUNC_DIGIT: begin
				if (mode_q == MODE_LOCKED) begin
					status_d = ST_LOCKED;
				end else if (pos_inc != POS_W'(CODE_LEN)) begin
					entered_d = code_new;
					pos_d     = pos_inc;
					sec_d     = '0;
					status_d  = ST_DIGIT;
				end else begin
					// last digit closes the session
					pos_d     = '0;
					entered_d = '0;
					sec_d     = '0;
					unique case (mode_q)
						MODE_VERIFY: begin
							if (code_new == stored_q) begin
								trials_d = max_trials_q;
								status_d = ST_GRANTED;
							end else if (trials_q <= TRIAL_W'(1)) begin
								trials_d = '0;
								mode_d   = MODE_LOCKED;
								status_d = ST_LOCKED;
							end else begin
								trials_d = trials_q - TRIAL_W'(1);
								status_d = ST_WRONG;
							end
						end
						MODE_NEW: begin
							first_d  = code_new;
							mode_d   = MODE_REENTER;
							status_d = ST_DIGIT;
						end
						default: begin
							if (code_new == first_q) begin
								stored_d = code_new;
								mode_d   = MODE_VERIFY;
								status_d = ST_CHANGED;
							end else begin
								mode_d   = MODE_NEW;
								status_d = ST_MISMATCH;
							end
						end
					endcase
				end
			end
			FUNC_TICK: begin
				if (mode_q == MODE_LOCKED) begin
					if (sec_inc >= lockout_sec_q) begin
						mode_d    = MODE_VERIFY;
						pos_d     = '0;
						entered_d = '0;
						sec_d     = '0;
						trials_d  = max_trials_q;
						status_d  = ST_LOCK_OVER;
					end else begin
						sec_d = sec_inc;
					end
				end else if (pos_q == '0) begin
					if (sec_inc > SEC_W'(limit)) begin
						mode_d    = MODE_VERIFY;
						entered_d = '0;
						sec_d     = '0;
						status_d  = ST_TIMEOUT;
					end else begin
						sec_d = sec_inc;
					end
				end
			end
			FUNC_CHANGE: begin
				if (mode_q == MODE_LOCKED) begin
					status_d = ST_LOCKED;
				end else begin
					mode_d    = MODE_NEW;
					pos_d     = '0;
					entered_d = '0;
					sec_d     = '0;
				end
			end
			FUNC_NOP: ;
			default: ;
		endcase
	end

	always_comb begin
		result.status         = status_d;
		result.trials_left    = trials_d;
		result.digits_entered = pos_d;
		result.mode           = mode_d;
		result.lock_remaining = '0;
		if (mode_d == MODE_LOCKED && lockout_sec_q > sec_d) begin
			result.lock_remaining = lockout_sec_q - sec_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_VERIFY;
			pos_q     <= '0;
			entered_q <= '0;
			first_q   <= '0;
			stored_q  <= '0;
			trials_q  <= MAX_TRIALS_RST;
			sec_q     <= '0;
		end else if (step) begin
			mode_q    <= mode_d;
			pos_q     <= pos_d;
			entered_q <= entered_d;
			first_q   <= first_d;
			stored_q  <= stored_d;
			trials_q  <= trials_d;
			sec_q     <= sec_d;
		end
	end

	`KCL_ASSERT_IMPL(a_locked_no_trials, mode_q == MODE_LOCKED, trials_q == '0, "trials left while locked")
	`KCL_ASSERT_IMPL(a_locked_no_digits, mode_q == MODE_LOCKED, pos_q == '0, "digits held while locked")
	`KCL_ASSERT(a_pos_range, pos_q < POS_W'(CODE_LEN), "digit position out of range")
	`KCL_ASSERT_IMPL(a_idle_after_digit, pos_q != '0, sec_q == '0, "idle count running mid-session")
endmodule
`default_nettype wire

>>> rtl/kcl_out_stage.sv
// result register of the code lock
`default_nettype none
module kcl_out_stage (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire kcl_pkg::kcl_result_t result_in,
	input  wire logic                 out_stall,
	output logic                      out_valid,
	output logic                      ready,
	output kcl_pkg::kcl_result_t      result_q
);
	import kcl_pkg::*;

	// room when empty or when the held transaction leaves now
	assign ready = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ready) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_in;
		end
	end
endmodule
`default_nettype wire

>>> rtl/keypad_code_lock_with_lockout.sv
// top level of the keypad code lock with trial counting and lockout
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | to lock   | in_valid / in_stall  | func, digit
//   out     | from lock | out_valid / out_stall| status, trials_left, lock_remaining,
//           |           |                      | digits_entered, mode
//   cfg     | to lock   | cfg_we               | cfg_index, cfg_data
//
// one transaction per cycle sustained while out_stall is low; path runs input register to result register
// the whole state update is a single short pass through the core, so the next event sees it
// reset (arst_n low) empties both stages and loads the register defaults and lock state
// out_stall holds the result register and, once the input register is also full, raises in_stall
// the input register keeps taking a transaction while a finished result waits to be taken
`default_nettype none
module keypad_code_lock_with_lockout (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// event channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [kcl_pkg::FUNC_W-1:0]     func,
	input  wire logic                           digit,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [kcl_pkg::STAT_W-1:0]          status,
	output logic [kcl_pkg::TRIAL_W-1:0]         trials_left,
	output logic [kcl_pkg::SEC_W-1:0]           lock_remaining,
	output logic [kcl_pkg::POS_W-1:0]           digits_entered,
	output logic [kcl_pkg::MODE_W-1:0]          mode,
	// register writes
	input  wire logic                           cfg_we,
	input  wire logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [kcl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import kcl_pkg::*;

	kcl_item_t   in_item;
	kcl_item_t   item_s1;
	logic        valid_s1;
	logic        out_ready;
	logic        step;
	kcl_cfg_t    cfg;
	kcl_result_t result_d;
	kcl_result_t result_q;

	assign in_item.func  = func;
	assign in_item.digit = digit;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// an event commits to lock state exactly when it moves into the result register
	assign step = valid_s1 && out_ready;

	kcl_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.advance  (out_ready),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	kcl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.item   (item_s1),
		.result (result_d)
	);

	kcl_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.result_in (result_d),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.ready     (out_ready),
		.result_q  (result_q)
	);

	assign status         = result_q.status;
	assign trials_left    = result_q.trials_left;
	assign lock_remaining = result_q.lock_remaining;
	assign digits_entered = result_q.digits_entered;
	assign mode           = result_q.mode;
endmodule
`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the keypad code lock with trial counting and lockout
`timescale 1ns / 1ps

import kcl_pkg::*;

// lock states as the result port reports them
typedef enum logic [MODE_W-1:0] {
	MODE_VERIFY  = 2'd0,
	MODE_LOCKED  = 2'd1,
	MODE_NEW     = 2'd2,
	MODE_REENTER = 2'd3
} lock_mode_t;

// tracks the lock state, predicts each outcome and compares it with the one seen
class code_lock_tracker;
	// register copies
	logic [TMO_W-1:0]     entry_tmo;
	logic [TMO_W-1:0]     new_tmo;
	logic [TRIAL_W-1:0]   max_trials;
	logic [SEC_W-1:0]     lock_secs;
	// lock state
	lock_mode_t           lmode;
	logic [POS_W-1:0]     pos;
	logic [CODE_LEN-1:0]  entered;
	logic [CODE_LEN-1:0]  first_code;
	logic [CODE_LEN-1:0]  stored;
	logic [TRIAL_W-1:0]   trials;
	logic [SEC_W-1:0]     idle_secs;
	// outcomes still to come, oldest first
	kcl_result_t          pending_outcomes[$];
	int                   mismatch_count = 0;
	int                   outcome_idx = 0;

	function void power_on();
		entry_tmo  = ENTRY_TMO_RST;
		new_tmo    = NEW_TMO_RST;
		max_trials = MAX_TRIALS_RST;
		lock_secs  = LOCKOUT_SEC_RST;
		lmode      = MODE_VERIFY;
		pos        = '0;
		entered    = '0;
		first_code = '0;
		stored     = '0;
		trials     = MAX_TRIALS_RST;
		idle_secs  = '0;
		pending_outcomes.delete();
	endfunction

	function void write_reg(kcl_reg_t r, logic [CFG_DATA_W-1:0] v);
		case (r)
			REG_ENTRY_TMO:   entry_tmo  = v[TMO_W-1:0];
			REG_NEW_TMO:     new_tmo    = v[TMO_W-1:0];
			REG_MAX_TRIALS:  max_trials = v[TRIAL_W-1:0];
			REG_LOCKOUT_SEC: lock_secs  = v[SEC_W-1:0];
			default: ;
		endcase
	endfunction

	function void open_session(lock_mode_t m);
		lmode     = m;
		pos       = '0;
		entered   = '0;
		idle_secs = '0;
	endfunction

	function kcl_status_t close_session();
		logic [CODE_LEN-1:0] c;
		kcl_status_t         st;
		c  = entered;
		st = ST_NONE;
		case (lmode)
			MODE_VERIFY: begin
				open_session(MODE_VERIFY);
				if (c == stored) begin
					trials = max_trials;
					st     = ST_GRANTED;
				end else if (trials <= 1) begin
					trials = '0;
					lmode  = MODE_LOCKED;
					st     = ST_LOCKED;
				end else begin
					trials = trials - 1'b1;
					st     = ST_WRONG;
				end
			end
			MODE_NEW: begin
				first_code = c;
				open_session(MODE_REENTER);
				st = ST_DIGIT;
			end
			default: begin
				if (c == first_code) begin
					stored = c;
					open_session(MODE_VERIFY);
					st = ST_CHANGED;
				end else begin
					open_session(MODE_NEW);
					st = ST_MISMATCH;
				end
			end
		endcase
		return st;
	endfunction

	function kcl_status_t key_press(logic d);
		if (lmode == MODE_LOCKED)
			return ST_LOCKED;
		if (pos >= CODE_LEN)
			pos = '0;
		entered   = entered | (CODE_LEN'(d) << pos);
		pos       = pos + 1'b1;
		idle_secs = '0;
		if (pos >= CODE_LEN)
			return close_session();
		return ST_DIGIT;
	endfunction

	function kcl_status_t second_tick();
		logic [TMO_W-1:0] limit;
		if (lmode == MODE_LOCKED) begin
			if (idle_secs != SEC_MAX)
				idle_secs = idle_secs + 1'b1;
			if (idle_secs >= lock_secs) begin
				open_session(MODE_VERIFY);
				trials = max_trials;
				return ST_LOCK_OVER;
			end
			return ST_NONE;
		end
		if (pos != 0)
			return ST_NONE;
		if (idle_secs != SEC_MAX)
			idle_secs = idle_secs + 1'b1;
		limit = (lmode == MODE_NEW) ? new_tmo : entry_tmo;
		if (idle_secs > SEC_W'(limit)) begin
			open_session(MODE_VERIFY);
			return ST_TIMEOUT;
		end
		return ST_NONE;
	endfunction

	function void apply_event(logic [FUNC_W-1:0] f, logic d);
		kcl_result_t r;
		kcl_status_t st;
		st = ST_NONE;
		case (f)
			FUNC_DIGIT:  st = key_press(d);
			FUNC_TICK:   st = second_tick();
			FUNC_CHANGE: begin
				if (lmode == MODE_LOCKED)
					st = ST_LOCKED;
				else
					open_session(MODE_NEW);
			end
			default: ;
		endcase
		r.status         = st;
		r.trials_left    = trials;
		r.lock_remaining = '0;
		if (lmode == MODE_LOCKED && lock_secs > idle_secs)
			r.lock_remaining = lock_secs - idle_secs;
		r.digits_entered = pos;
		r.mode           = lmode;
		pending_outcomes.push_back(r);
	endfunction

	task report_mismatch(string what);
		// keep the log short when something goes badly wrong
		if (mismatch_count < 64)
			$display("mismatch at outcome %0d: %s", outcome_idx, what);
		mismatch_count++;
	endtask

	task compare_outcome(kcl_result_t got);
		kcl_result_t want;
		if (pending_outcomes.size() == 0) begin
			report_mismatch($sformatf("unexpected outcome, status %0d", got.status));
			return;
		end
		want = pending_outcomes.pop_front();
		if (got.status !== want.status)
			report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
		if (got.trials_left !== want.trials_left)
			report_mismatch($sformatf("trials_left %0d, expected %0d",
				got.trials_left, want.trials_left));
		if (got.lock_remaining !== want.lock_remaining)
			report_mismatch($sformatf("lock_remaining %0d, expected %0d",
				got.lock_remaining, want.lock_remaining));
		if (got.digits_entered !== want.digits_entered)
			report_mismatch($sformatf("digits_entered %0d, expected %0d",
				got.digits_entered, want.digits_entered));
		if (got.mode !== want.mode)
			report_mismatch($sformatf("mode %0d, expected %0d", got.mode, want.mode));
		outcome_idx++;
	endtask

	task close_out();
		if (pending_outcomes.size() != 0)
			report_mismatch($sformatf("%0d outcomes never arrived", pending_outcomes.size()));
	endtask
endclass

module testbench;
	localparam int WATCHDOG_LIMIT = 5000;   // cycles without any transaction
	localparam int DRAIN_CYCLES   = 4;      // drain of input and result registers plus margin

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [FUNC_W-1:0]     func = FUNC_NOP;
	logic                  digit = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [STAT_W-1:0]     status;
	logic [TRIAL_W-1:0]    trials_left;
	logic [SEC_W-1:0]      lock_remaining;
	logic [POS_W-1:0]      digits_entered;
	logic [MODE_W-1:0]     mode;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_ENTRY_TMO;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	kcl_result_t      observed;
	code_lock_tracker tracker = new;

	// sender burst bookkeeping and a guess at the stored code
	int                  burst_left = 0;
	logic [CODE_LEN-1:0] known_code = '0;
	// receiver stall pattern
	int                  stall_left = 0;
	int                  stall_style = 0;
	int                  stall_cnt = 0;
	int                  quiet_cycles = 0;

	assign observed = {status, trials_left, lock_remaining, digits_entered, mode};

	keypad_code_lock_with_lockout dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.digit          (digit),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.trials_left    (trials_left),
		.lock_remaining (lock_remaining),
		.digits_entered (digits_entered),
		.mode           (mode),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// monitors: predict on each accepted event, check each accepted outcome
	// inputs are sampled before this edge's updates land, so no ordering race
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.apply_event(func, digit);
			if (out_valid && !out_stall)
				tracker.compare_outcome(observed);
			// watchdog: nothing moving on either channel for too long
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[keypad_code_lock_with_lockout] ERROR");
				$finish;
			end
		end
	end

	// receiver: switch between randomly chosen stall styles, each held for a random stretch
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_style = $urandom_range(0, 3);
			stall_left  = $urandom_range(10, 80);
		end
		stall_left--;
		stall_cnt++;
		case (stall_style)
			0: out_stall <= 1'b0;                          // free flow
			1: out_stall <= ($urandom_range(0, 3) == 0);   // light stalls
			2: out_stall <= ($urandom_range(0, 9) < 6);    // heavy stalls
			default: out_stall <= ((stall_cnt % 5) < 2);   // periodic
		endcase
	end

	// one event transaction; bursts of random length with random gaps between them
	task automatic post_event(kcl_func_t f, logic d);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		in_valid <= 1'b1;
		func     <= f;
		digit    <= d;
		do @(posedge clk); while (in_stall);
		burst_left--;
	endtask

	// a whole code, digit 0 first
	task automatic key_in_code(logic [CODE_LEN-1:0] c);
		for (int k = 0; k < CODE_LEN; k++)
			post_event(FUNC_DIGIT, c[k]);
	endtask

	task automatic tick_run(int n);
		repeat (n) post_event(FUNC_TICK, 1'($urandom));
	endtask

	// stop sending and wait until every outcome is in and the pipe is empty
	task automatic settle();
		in_valid   <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (tracker.pending_outcomes.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(kcl_reg_t r, logic [CFG_DATA_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		@(posedge clk);
		tracker.write_reg(r, v);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(logic [CFG_DATA_W-1:0] e, logic [CFG_DATA_W-1:0] n,
			logic [CFG_DATA_W-1:0] m, logic [CFG_DATA_W-1:0] l);
		set_reg(REG_ENTRY_TMO, e);
		set_reg(REG_NEW_TMO, n);
		set_reg(REG_MAX_TRIALS, m);
		set_reg(REG_LOCKOUT_SEC, l);
	endtask

	// mostly well-formed sessions with random content, some noise
	task automatic random_traffic(int quota);
		int                  done;
		int                  n;
		int                  t;
		int                  longest;
		logic [CODE_LEN-1:0] c;
		done = 0;
		while (done < quota) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					// verify attempt, often with the code believed to be stored
					c = $urandom_range(0, 1) ? known_code : CODE_LEN'($urandom);
					key_in_code(c);
					done += CODE_LEN;
				end
				3, 4: begin
					// change session, mostly with a matching re-entry
					post_event(FUNC_CHANGE, 1'($urandom));
					c = CODE_LEN'($urandom);
					key_in_code(c);
					if ($urandom_range(0, 3) != 0) begin
						key_in_code(c);
						known_code = c;
					end else begin
						key_in_code(CODE_LEN'($urandom));
					end
					done += 2 * CODE_LEN + 1;
				end
				5, 6: begin
					// idle seconds, now and then long enough for a timeout or lockout end
					longest = tracker.entry_tmo;
					if (tracker.new_tmo > longest)
						longest = tracker.new_tmo;
					if (tracker.lock_secs > longest)
						longest = tracker.lock_secs;
					n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, longest + 2)
						: $urandom_range(1, 4);
					// keep the phase near its share of transactions
					if (n > quota - done)
						n = quota - done;
					tick_run(n);
					done += n;
				end
				7: begin
					// broken session: a few digits, then ticks that must be ignored
					n = $urandom_range(1, CODE_LEN - 1);
					repeat (n) post_event(FUNC_DIGIT, 1'($urandom));
					t = $urandom_range(1, 3);
					tick_run(t);
					done += n + t;
				end
				default: begin
					post_event(kcl_func_t'($urandom_range(0, 3)), 1'($urandom));
					done += 1;
				end
			endcase
		end
	endtask

	initial begin
		tracker.power_on();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: unused function, stray tick, stored code of zeros
		post_event(FUNC_NOP, 1'b1);
		post_event(FUNC_TICK, 1'b1);
		post_event(FUNC_NOP, 1'b0);
		key_in_code(4'b0000);
		// change session with a mismatch on re-entry, then a good one
		post_event(FUNC_CHANGE, 1'b1);
		key_in_code(4'b0101);
		key_in_code(4'b1101);
		key_in_code(4'b0101);
		key_in_code(4'b0101);
		known_code = 4'b0101;

		// single trial, short lockout and timeouts
		settle();
		configure(10'd2, 10'd1, 10'd1, 10'd3);
		key_in_code(known_code);        // grant refills the single trial
		key_in_code(~known_code);       // last miss starts the lockout
		post_event(FUNC_DIGIT, 1'b1);   // ignored while locked
		post_event(FUNC_CHANGE, 1'b0);  // ignored while locked
		tick_run(3);                    // lockout ends
		tick_run(3);                    // entry timeout
		post_event(FUNC_DIGIT, 1'b1);
		tick_run(2);                    // ticks after the first digit do nothing
		post_event(FUNC_CHANGE, 1'b0);  // restart as a new-code session
		tick_run(2);                    // new-code timeout

		// no trials at all and a zero-length lockout
		settle();
		configure(10'd2, 10'd1, 10'd0, 10'd0);
		key_in_code(4'b1111);           // miss on the last trial
		tick_run(1);                    // lockout over, trials refilled to zero
		key_in_code(4'b1111);           // miss with no trials left
		tick_run(1);

		// longest lockout, then cut short by a smaller setting
		settle();
		configure(10'd255, 10'd255, 10'd1, 10'd1023);
		key_in_code(~known_code);
		tick_run(4);
		settle();
		set_reg(REG_LOCKOUT_SEC, 10'd6);
		tick_run(2);

		// random phases under several settings, extremes first
		for (int ph = 0; ph < 6; ph++) begin
			settle();
			case (ph)
				0: configure(10'd255, 10'd255, 10'd15, 10'd20);
				1: configure(10'd1, 10'd1, 10'd1, 10'd1);
				// upper data bits set: registers keep only their own width
				2: configure(10'h300 | 10'($urandom_range(1, 6)),
					10'h100 | 10'($urandom_range(1, 6)),
					10'h3F0 | 10'($urandom_range(0, 4)), 10'($urandom_range(0, 12)));
				default: configure(10'($urandom_range(1, 6)), 10'($urandom_range(1, 6)),
					10'($urandom_range(0, 4)), 10'($urandom_range(0, 12)));
			endcase
			random_traffic(64);
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		tracker.close_out();
		if (tracker.mismatch_count == 0)
			$display("[keypad_code_lock_with_lockout] OK");
		else
			$display("[keypad_code_lock_with_lockout] ERROR");
		$finish;
	end
endmodule
